[rtl/core/sorted_peak_tolerance_matcher_unit_macros.svh]
// assertion macros shared by the peak matcher rtl
`ifndef SORTED_PEAK_TOLERANCE_MATCHER_UNIT_MACROS_SVH
`define SORTED_PEAK_TOLERANCE_MATCHER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SPMT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("peak matcher check failed");

// next-cycle implication, disabled in reset
`define SPMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("peak matcher check failed");

`endif

[rtl/core/spmt_pkg.sv]
// shared types and constants of the peak matcher
package spmt_pkg;

  localparam int MAX_PEAKS_DEFAULT = 4096;
  localparam int MASS_W = 32;
  localparam int TOL_W = 32;
  localparam int INDEX_W = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd42950;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_MATCH = 2'd2;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_APPEND,
    K_MATCH,
    K_MISS
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [MASS_W-1:0] mass;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic done;
    logic matched;
    logic [INDEX_W-1:0] peak_index;
    logic list_full;
  } result_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_THR,
    B_SCAN
  } back_state_t;

endpackage

[rtl/core/spmt_front.sv]
// front end: accepts items and classifies them for the queue
module spmt_front (
  input  logic                      start,
  input  logic [1:0]                action,
  input  logic [spmt_pkg::MASS_W-1:0] mass,
  input  spmt_pkg::q_status_t       q_status,
  output logic                      busy,
  output logic                      push,
  output spmt_pkg::item_t           push_item
);
  import spmt_pkg::*;

  logic keep;

  assign busy = q_status.full;

  always_comb begin
    keep = 1'b1;
    push_item.mass = mass;
    unique case (action)
      ACT_CLEAR: begin
        push_item.kind = K_CLEAR;
      end
      ACT_APPEND: begin
        push_item.kind = K_APPEND;
      end
      ACT_MATCH: begin
        // zero fragment mass can never match
        push_item.kind = (mass == '0) ? K_MISS : K_MATCH;
      end
      default: begin
        push_item.kind = K_CLEAR;
        keep = 1'b0;
      end
    endcase
  end

  assign push = start && !busy && keep;

endmodule

[rtl/core/spmt_queue.sv]
// short item queue between front and back
module spmt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  spmt_pkg::item_t     push_item,
  input  logic                pop,
  output spmt_pkg::item_t     head,
  output spmt_pkg::q_status_t status
);
  import spmt_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  item_t slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
    bump = (ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  assign head = slots[rd_ptr];
  assign status.full = (fill == FW'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

`include "sorted_peak_tolerance_matcher_unit_macros.svh"

  `SPMT_ASSERT_NOW(a_no_push_full, clk, rst, status.full, !push)
  `SPMT_ASSERT_NOW(a_no_pop_empty, clk, rst, status.empty, !pop)
  `SPMT_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= FW'(QUEUE_DEPTH))

endmodule

[rtl/core/spmt_back.sv]
// back end: peak store, append and tolerance scan
module spmt_back #(
  parameter int MAX_PEAKS = spmt_pkg::MAX_PEAKS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  spmt_pkg::item_t            head,
  input  logic                       q_empty,
  output logic                       pop,
  input  logic [spmt_pkg::TOL_W-1:0] tolerance,
  output spmt_pkg::result_t          result
);
  import spmt_pkg::*;

  localparam int AW = $clog2(MAX_PEAKS);
  localparam int CW = $clog2(MAX_PEAKS + 1);

  logic [MASS_W-1:0] peak_mem [MAX_PEAKS];

  back_state_t state;
  back_state_t state_next;
  logic [CW-1:0] count;
  logic [MASS_W-1:0] frag;
  logic [MASS_W+TOL_W-1:0] prod;
  logic [MASS_W:0] thr;
  logic [AW-1:0] chk_idx;
  logic [MASS_W-1:0] rd_data;
  result_t result_next;

  logic wr_en;
  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic clear_cnt;
  logic store_full;
  logic last_peak;
  logic [MASS_W-1:0] delta;
  logic hit;
  logic above;

  assign store_full = (count == CW'(MAX_PEAKS));
  assign last_peak = ((CW'(chk_idx) + CW'(1)) == count);
  assign delta = (rd_data >= frag) ? (rd_data - frag) : (frag - rd_data);
  // delta * 2^32 < tol * frag, with the low product half folded into thr
  assign hit = ({1'b0, delta} < thr);
  assign above = (rd_data > frag);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty && head.kind == K_MATCH && count != '0) begin
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        state_next = B_THR;
      end
      B_THR: begin
        state_next = B_SCAN;
      end
      B_SCAN: begin
        if (hit || above || last_peak) begin
          state_next = B_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    pop = 1'b0;
    wr_en = 1'b0;
    rd_en = 1'b0;
    clear_cnt = 1'b0;
    rd_addr = chk_idx + AW'(1);
    result_next = '0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (head.kind)
            K_CLEAR: begin
              clear_cnt = 1'b1;
            end
            K_APPEND: begin
              result_next.done = 1'b1;
              result_next.list_full = store_full;
              wr_en = !store_full;
            end
            K_MATCH: begin
              result_next.done = (count == '0);
            end
            K_MISS: begin
              result_next.done = 1'b1;
            end
          endcase
        end
      end
      B_MUL: begin
      end
      B_THR: begin
        rd_en = 1'b1;
        rd_addr = '0;
      end
      B_SCAN: begin
        priority if (hit) begin
          result_next.done = 1'b1;
          result_next.matched = 1'b1;
          result_next.peak_index = INDEX_W'(chk_idx);
        end else if (above || last_peak) begin
          result_next.done = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      count <= '0;
      result <= '0;
    end else begin
      state <= state_next;
      result <= result_next;
      if (clear_cnt) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frag <= head.mass;
    end
    if (state == B_MUL) begin
      prod <= {32'd0, tolerance} * {32'd0, frag};
    end
    if (state == B_THR) begin
      thr <= {1'b0, prod[MASS_W+TOL_W-1:TOL_W]} + {32'd0, (prod[TOL_W-1:0] != '0)};
      chk_idx <= '0;
    end else if (state == B_SCAN && rd_en) begin
      chk_idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      peak_mem[count[AW-1:0]] <= head.mass;
    end
    if (rd_en) begin
      rd_data <= peak_mem[rd_addr];
    end
  end

`include "sorted_peak_tolerance_matcher_unit_macros.svh"

  `SPMT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(MAX_PEAKS))
  `SPMT_ASSERT_NOW(a_scan_in_list, clk, rst, state == B_SCAN, CW'(chk_idx) < count)
  `SPMT_ASSERT_NEXT(a_thr_to_scan, clk, rst, state == B_THR, state == B_SCAN)
  `SPMT_ASSERT_NOW(a_busy_no_pop, clk, rst, state != B_IDLE, !pop)

endmodule

[rtl/core/sorted_peak_tolerance_matcher_unit.sv]
// top level of the sorted peak tolerance matcher
//
// command channel: an item (action, mass) is taken at a clock edge with start
// high and busy low. action clear empties the peak list, append stores mass
// as the next peak, match scans the list for the first peak within the
// relative tolerance of the fragment mass; action code 3 is dropped.
// result channel: done is high for exactly one cycle with matched, peak_index
// and list_full; the receiver cannot stall it. clear gives no result, append
// and match give one each.
// config channel: cfg_data is written to the tolerance register (0.32
// fraction) on cfg_valid with cfg_ready, which is always high; write only
// while no item is pending.
// sequence: an append or a trivial match reports through the registered result
// once it leaves the queue. a scanning match goes through the multiply,
// threshold and scan states after it is taken off the queue; the scan reads one peak
// per cycle from the single-port peak memory and stops at a hit, a larger
// peak, or the end of the list.
// a two-entry queue lets start be taken while a scan runs; busy rises when
// the queue is full.
// reset: peak list empty, tolerance back to about 10 ppm, queue drained.
module sorted_peak_tolerance_matcher_unit #(
  parameter int MAX_PEAKS = spmt_pkg::MAX_PEAKS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [spmt_pkg::MASS_W-1:0]  mass,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spmt_pkg::TOL_W-1:0]   cfg_data,
  output logic                         done,
  output logic                         matched,
  output logic [spmt_pkg::INDEX_W-1:0] peak_index,
  output logic                         list_full
);
  import spmt_pkg::*;

  // relative tolerance register
  logic [TOL_W-1:0] tolerance;

  // front to queue
  logic push;
  item_t push_item;
  q_status_t q_status;

  // queue to back
  item_t head;
  logic pop;
  result_t result;

  // the user issues config writes only while idle, which the block leaves unenforced; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  spmt_front u_front (
    .start     (start),
    .action    (action),
    .mass      (mass),
    .q_status  (q_status),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  spmt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  spmt_back #(
    .MAX_PEAKS (MAX_PEAKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_status.empty),
    .pop       (pop),
    .tolerance (tolerance),
    .result    (result)
  );

  // registered result, one-cycle strobe
  assign done = result.done;
  assign matched = result.matched;
  assign peak_index = result.peak_index;
  assign list_full = result.list_full;

endmodule

[tb/sv/sorted_peak_tolerance_matcher_unit_tb.sv]
// self-checking testbench of the sorted peak tolerance matcher
`timescale 1ns / 1ps

module sorted_peak_tolerance_matcher_unit_tb;
  import spmt_pkg::*;

  // action code the block drops without a result
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int PEAKS = MAX_PEAKS_DEFAULT;
  localparam int N_DIRECTED = 23;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 50;
  // cycles allowed after the last result for a trailing clear to finish
  localparam int SETTLE_CYCLES = 16;

  // one result item as the block reports it
  typedef struct packed {
    logic matched;
    logic [INDEX_W-1:0] peak_index;
    logic list_full;
  } peak_result_t;

  // one row of the directed table: item, and the result when typed in by hand
  typedef struct packed {
    logic [1:0] act;
    logic [MASS_W-1:0] m_val;
    logic given;
    peak_result_t res;
  } peak_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] action;
  logic [MASS_W-1:0] mass;
  logic cfg_valid;
  logic cfg_ready;
  logic [TOL_W-1:0] cfg_data;
  logic done;
  logic matched;
  logic [INDEX_W-1:0] peak_index;
  logic list_full;

  // predictor state: its own copy of the peak list and the tolerance
  logic [MASS_W-1:0] peak_mem [PEAKS];
  int peak_cnt;
  logic [TOL_W-1:0] tol_model;

  // expected results in order of acceptance
  peak_result_t result_q [$];

  // hand-typed expectation that goes with the item on the command port
  bit typed_valid;
  peak_result_t typed_res;

  int errors;
  int items_taken;
  int results_seen;
  int hits_seen;
  int drops_seen;
  int tol_writes;

  bit emits;
  peak_result_t predicted;
  peak_result_t exp_r;

  peak_row_t directed_rows [N_DIRECTED];
  logic [TOL_W-1:0] phase_tol [N_PHASES];
  int phase_gap [N_PHASES];
  int row_i;
  int ph;

  sorted_peak_tolerance_matcher_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .mass(mass),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .matched(matched),
    .peak_index(peak_index),
    .list_full(list_full)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // work out what one accepted item does to the list and what it reports
  function automatic void predict_peak_item(input logic [1:0] act, input logic [MASS_W-1:0] m,
                                            output bit has_res, output peak_result_t r);
    logic [63:0] diff;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [MASS_W-1:0] pk;
    bit stop;
    int k;
    r = '0;
    has_res = 1'b0;
    case (act)
      ACT_CLEAR: begin
        peak_cnt = 0;
      end
      ACT_APPEND: begin
        has_res = 1'b1;
        if (peak_cnt < PEAKS) begin
          peak_mem[peak_cnt] = m;
          peak_cnt++;
        end else begin
          r.list_full = 1'b1;
        end
      end
      ACT_MATCH: begin
        has_res = 1'b1;
        // zero fragment never matches
        if (m != '0) begin
          stop = 1'b0;
          rhs = {32'd0, tol_model} * {32'd0, m};
          for (k = 0; k < peak_cnt && !stop; k++) begin
            pk = peak_mem[k];
            diff = (pk >= m) ? {32'd0, pk - m} : {32'd0, m - pk};
            lhs = diff << 32;
            if (lhs < rhs) begin
              r.matched = 1'b1;
              r.peak_index = k[INDEX_W-1:0];
              stop = 1'b1;
            end else if (pk > m) begin
              // scan ends at the first larger peak that misses
              stop = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // monitor: results first, then the item taken at this edge, then config
  always @(posedge clk) begin
    if (rst) begin
      peak_cnt = 0;
      tol_model = TOL_RESET;
    end else begin
      if (done) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: matched=%b peak_index=%0d list_full=%b",
                   $time, matched, peak_index, list_full);
        end else begin
          exp_r = result_q.pop_front();
          results_seen++;
          if (matched) hits_seen++;
          if (list_full) drops_seen++;
          if (matched !== exp_r.matched || peak_index !== exp_r.peak_index ||
              list_full !== exp_r.list_full) begin
            errors++;
            $display("%0t: mismatch expected matched=%b peak_index=%0d list_full=%b",
                     $time, exp_r.matched, exp_r.peak_index, exp_r.list_full);
            $display("%0t:          actual   matched=%b peak_index=%0d list_full=%b",
                     $time, matched, peak_index, list_full);
          end
        end
      end
      if (start && !busy) begin
        items_taken++;
        // predictor always runs so its list stays in step with typed rows
        predict_peak_item(action, mass, emits, predicted);
        if (emits) result_q.push_back(typed_valid ? typed_res : predicted);
      end
      if (cfg_valid && cfg_ready) begin
        tol_model = cfg_data;
        tol_writes++;
      end
    end
  end

  // present one item at the falling edge, hold it until the block takes it
  task automatic send_item(input logic [1:0] act, input logic [MASS_W-1:0] m, input bit fixed,
                           input peak_result_t res, input int gap_pct);
    int idle;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      idle = $urandom_range(1, 6);
      @(negedge clk);
      start <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    mass <= m;
    typed_valid = fixed;
    typed_res = res;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and let every outstanding item finish
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // tolerance write, only ever called with the block drained
  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random part: mostly clear, ascending peaks, then matches near those peaks;
  // the rest is loose items of any action and mass
  task automatic run_random_phase(input int gap_pct, input int n_items);
    int sent;
    int len;
    int n_match;
    int j;
    logic [63:0] acc;
    logic [63:0] prod;
    logic [MASS_W-1:0] pk;
    logic [MASS_W-1:0] d0;
    logic [MASS_W-1:0] off;
    logic [MASS_W-1:0] frag;
    logic [1:0] act;
    logic [MASS_W-1:0] peaks_q [$];
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        peaks_q.delete();
        send_item(ACT_CLEAR, $urandom, 1'b0, '0, gap_pct);
        // short lists keep scans fast, a few long ones stretch the scan
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        acc = ($urandom_range(0, 3) == 0) ? {32'd0, $urandom} :
              {32'd0, $urandom_range(0, 32'h0400_0000)};
        for (j = 0; j < len; j++) begin
          if ($urandom_range(0, 15) == 0) begin
            // out-of-order peak breaks the sorted assumption
            pk = $urandom;
          end else begin
            acc = acc + 64'($urandom_range(1, 32'h0002_0000));
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
            pk = acc[31:0];
          end
          peaks_q.push_back(pk);
          send_item(ACT_APPEND, pk, 1'b0, '0, gap_pct);
        end
        n_match = $urandom_range(2, 10);
        for (j = 0; j < n_match; j++) begin
          if (peaks_q.size() == 0 || $urandom_range(0, 7) == 0) begin
            frag = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
          end else begin
            pk = peaks_q[$urandom_range(0, peaks_q.size() - 1)];
            // offset around the tolerance window edge of the chosen peak
            prod = {32'd0, tol_model} * {32'd0, pk};
            d0 = prod[63:32];
            case ($urandom_range(0, 4))
              0: off = '0;
              1: off = d0;
              2: off = d0 + 1;
              3: off = (d0 == 0) ? '0 : d0 - 1;
              default: off = (d0 == 0) ? '0 : $urandom_range(0, d0);
            endcase
            if ($urandom_range(0, 1) == 0) begin
              acc = {32'd0, pk} + {32'd0, off};
              if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
              frag = acc[31:0];
            end else begin
              frag = (off > pk) ? '0 : pk - off;
            end
          end
          send_item(ACT_MATCH, frag, 1'b0, '0, gap_pct);
        end
        sent += 1 + len + n_match;
      end else begin
        act = 2'($urandom_range(0, 3));
        send_item(act, $urandom, 1'b0, '0, gap_pct);
        // dropped actions do not count toward the phase
        if (act != ACT_UNUSED) sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = ACT_CLEAR;
    mass = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    typed_valid = 1'b0;
    typed_res = '0;
    errors = 0;
    items_taken = 0;
    results_seen = 0;
    hits_seen = 0;
    drops_seen = 0;
    tol_writes = 0;

    // directed table under the reset tolerance of about 10 ppm
    directed_rows = '{
      // empty list and zero fragment never match
      {ACT_MATCH,  32'h0001_0000, 1'b1, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'h0000_0000, 1'b1, 1'b0, 12'd0, 1'b0},
      // appends below capacity report nothing set
      {ACT_APPEND, 32'h0000_0000, 1'b1, 1'b0, 12'd0, 1'b0},
      {ACT_APPEND, 32'h0064_0000, 1'b1, 1'b0, 12'd0, 1'b0},
      {ACT_APPEND, 32'h0064_0003, 1'b1, 1'b0, 12'd0, 1'b0},
      {ACT_APPEND, 32'h00C8_0000, 1'b1, 1'b0, 12'd0, 1'b0},
      // exact, near, between peaks and above every peak
      {ACT_MATCH,  32'h0064_0000, 1'b0, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'h0064_0002, 1'b0, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'h0096_0000, 1'b0, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0},
      // unused action leaves no trace
      {ACT_UNUSED, 32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0},
      {ACT_APPEND, 32'hFFFF_FFFF, 1'b1, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'h0000_0000, 1'b1, 1'b0, 12'd0, 1'b0},
      // smaller peak at the tail: early stop hides it
      {ACT_APPEND, 32'h0010_0000, 1'b1, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'h0010_0000, 1'b0, 1'b0, 12'd0, 1'b0},
      {ACT_CLEAR,  32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'h0064_0000, 1'b1, 1'b0, 12'd0, 1'b0},
      {ACT_APPEND, 32'h8000_0000, 1'b1, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'h8000_0001, 1'b0, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'h7FFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0},
      {ACT_UNUSED, 32'h0000_0000, 1'b0, 1'b0, 12'd0, 1'b0},
      {ACT_MATCH,  32'h8000_0000, 1'b0, 1'b0, 12'd0, 1'b0}
    };

    // tolerance per random phase, with both extremes and the reset value
    phase_tol = '{32'd4294967, 32'hFFFF_FFFF, 32'd0, $urandom_range(1, 32'h0100_0000),
                  32'd1, TOL_RESET};
    // sender idle percentage per phase
    phase_gap = '{0, 63, 0, 16, 63, 16};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (row_i = 0; row_i < N_DIRECTED; row_i++)
      send_item(directed_rows[row_i].act, directed_rows[row_i].m_val,
                directed_rows[row_i].given, directed_rows[row_i].res, 0);
    drain_results();

    for (ph = 0; ph < N_PHASES; ph++) begin
      write_tolerance(phase_tol[ph]);
      run_random_phase(phase_gap[ph], PHASE_ITEMS);
      drain_results();
    end

    $display("run covered %0d items, %0d results (%0d hits, %0d appends dropped when full)",
             items_taken, results_seen, hits_seen, drops_seen);
    $display("tolerance written %0d times across %0d random phases after the directed table",
             tol_writes, N_PHASES);
    if (errors == 0 && result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin
    #8000000;
    $display("timeout with %0d results still expected", result_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
